/* hdl/rasp_pkg.sv */
// Shared types and constants for the range value store.
// Used by rasp_modstep and range_assign_kth_powsum_store; no dependencies.
package rasp_pkg;

   localparam int TypeWidth    = 2;
   localparam int PosWidth     = 10;
   localparam int OperandWidth = 48;
   localparam int ModWidth     = 32;
   localparam int AnswerWidth  = 48;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_ASSIGN = 2'd1,
      REQ_KTH    = 2'd2,
      REQ_POWSUM = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_USE,
      ST_REDUCE,
      ST_PSTEP,
      ST_MUL,
      ST_ACCUM,
      ST_KBIT,
      ST_DONE
   } state_type;

endpackage

/* hdl/rasp_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module rasp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rasp_modstep.sv */
// Shared modular step: (2*r + addend) mod m, with r and addend below m.
// Serves base reduction and shift-add modular multiply. Uses rasp_pkg.
module rasp_modstep (
   input  logic [rasp_pkg::ModWidth-1:0] r,
   input  logic [rasp_pkg::ModWidth-1:0] addend,
   input  logic [rasp_pkg::ModWidth-1:0] m,
   output logic [rasp_pkg::ModWidth-1:0] result
);

   localparam int W = rasp_pkg::ModWidth;

   logic [W:0] dbl;
   logic [W:0] dbl_red;
   logic [W:0] sum;
   logic [W:0] m_ext;

   always_comb begin
      m_ext   = {1'b0, m};
      dbl     = {r, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      sum     = dbl_red + {1'b0, addend};
      if (sum >= m_ext) begin
         sum = sum - m_ext;
      end
      result = sum[W-1:0];
   end

endmodule

/* hdl/range_assign_kth_powsum_store.sv */
// Range value store: add, assign, kth smallest and power sum over a range.
// Add/assign read and write each position of the range in turn; kth makes
// VALUE_WIDTH passes of a bitwise search over the range; power sum reduces
// each value mod the modulus and raises it to the operand's power, using the shared
// bit-serial modular step unit. One word is in flight at a time.
// Reset is synchronous; a clearing pass zeroes every position of the store.
module range_assign_kth_powsum_store #(
   parameter int POSITIONS   = 1024,
   parameter int VALUE_WIDTH = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // left_pos, right_pos, operand, modulus, zero fill
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // answer
   output logic         rsp_tuser   // rank_error
);

   localparam int AW = $clog2(POSITIONS);
   localparam int VW = VALUE_WIDTH;
   localparam int CW = $clog2(VW);
   localparam int MW = rasp_pkg::ModWidth;
   localparam int OW = rasp_pkg::OperandWidth;
   localparam int SW = ((VW > OW) ? VW : OW) + 1;

   rasp_pkg::state_type    state_ff, state_in;
   rasp_pkg::req_kind_type kind_ff, kind_in;
   logic [AW-1:0]  idx_ff, idx_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [OW-1:0]  opnd_ff, opnd_in, expo_ff, expo_in;
   logic [MW-1:0]  mod_ff, mod_in;
   logic [VW-1:0]  val_ff, val_in, ans_ff, ans_in;
   logic [CW-1:0]  bit_ff, bit_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic [MW-1:0]  r_ff, r_in, x_ff, x_in, y_ff, y_in;
   logic [MW-1:0]  base_ff, base_in, pacc_ff, pacc_in, sum_ff, sum_in;
   logic           phase_ff, phase_in, tgt_acc_ff, tgt_acc_in;
   logic [VW-1:0]  res_ff, res_in;
   logic           err_ff, err_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_err_ff, rsp_err_in;

   // ram
   logic           ram_we;
   logic [AW-1:0]  ram_addr;
   logic [VW-1:0]  ram_wdata, ram_rdata;

   // step unit
   logic [MW-1:0]  step_r, step_add, step_out;

   // request decode
   logic [31:0]    lp32, rp32;
   logic [AW-1:0]  lp, rp, new_lo, new_hi;
   logic [AW:0]    new_len;
   logic [OW-1:0]  f_opnd;
   logic [MW-1:0]  f_mod;

   logic           m_not_one;
   logic [VW-1:0]  cand, bitmask;
   logic [SW-1:0]  val_max, add_sum;
   logic [VW-1:0]  wr_val;
   logic [MW:0]    acc_sum;
   logic [VW-1:0]  ans_next;
   logic [63:0]    res_wide;

   rasp_ram #(.WIDTH(VW), .DEPTH(POSITIONS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   rasp_modstep u_step (
      .r      (step_r),
      .addend (step_add),
      .m      (mod_ff),
      .result (step_out)
   );

   always_comb begin
      lp32    = 32'(req_tdata[9:0]);
      rp32    = 32'(req_tdata[19:10]);
      lp      = (lp32 >= 32'(POSITIONS)) ? AW'(POSITIONS - 1) : AW'(lp32);
      rp      = (rp32 >= 32'(POSITIONS)) ? AW'(POSITIONS - 1) : AW'(rp32);
      new_lo  = (lp > rp) ? rp : lp;
      new_hi  = (lp > rp) ? lp : rp;
      new_len = (AW+1)'(new_hi) - (AW+1)'(new_lo) + (AW+1)'(1);
      f_opnd  = req_tdata[67:20];
      f_mod   = req_tdata[99:68];
   end

   always_comb begin
      m_not_one = (mod_ff != MW'(1));
      bitmask   = VW'(1) << bit_ff;
      cand      = ans_ff | (bitmask - VW'(1));
      val_max   = SW'({VW{1'b1}});
      add_sum   = SW'(ram_rdata) + SW'(opnd_ff);
      if (kind_ff == rasp_pkg::REQ_ADD) begin
         wr_val = (add_sum > val_max) ? {VW{1'b1}} : VW'(add_sum);
      end else begin
         wr_val = (SW'(opnd_ff) > val_max) ? {VW{1'b1}} : VW'(opnd_ff);
      end
      acc_sum  = {1'b0, sum_ff} + {1'b0, pacc_ff};
      if (acc_sum >= {1'b0, mod_ff}) begin
         acc_sum = acc_sum - {1'b0, mod_ff};
      end
      ans_next = (64'(cnt_ff) >= 64'(opnd_ff)) ? ans_ff : (ans_ff | bitmask);
      step_r   = r_ff;
      if (state_ff == rasp_pkg::ST_REDUCE) begin
         step_add = MW'(val_ff[bit_ff] & m_not_one);
      end else begin
         step_add = y_ff[MW-1] ? x_ff : '0;
      end
      res_wide = 64'(res_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rasp_pkg::ST_CLEAR: begin
            if (idx_ff == AW'(POSITIONS - 1)) state_in = rasp_pkg::ST_IDLE;
         end
         rasp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == rasp_pkg::REQ_KTH &&
                   (f_opnd == '0 || 64'(f_opnd) > 64'(new_len))) begin
                  state_in = rasp_pkg::ST_DONE;
               end else if (req_tuser == rasp_pkg::REQ_POWSUM && f_mod == '0) begin
                  state_in = rasp_pkg::ST_DONE;
               end else begin
                  state_in = rasp_pkg::ST_ISSUE;
               end
            end
         end
         rasp_pkg::ST_ISSUE: state_in = rasp_pkg::ST_USE;
         rasp_pkg::ST_USE: begin
            case (kind_ff)
               rasp_pkg::REQ_ADD, rasp_pkg::REQ_ASSIGN: begin
                  state_in = (idx_ff == hi_ff) ? rasp_pkg::ST_IDLE : rasp_pkg::ST_ISSUE;
               end
               rasp_pkg::REQ_KTH: begin
                  state_in = (idx_ff == hi_ff) ? rasp_pkg::ST_KBIT : rasp_pkg::ST_ISSUE;
               end
               default: state_in = rasp_pkg::ST_REDUCE;
            endcase
         end
         rasp_pkg::ST_REDUCE: begin
            if (bit_ff == '0) state_in = rasp_pkg::ST_PSTEP;
         end
         rasp_pkg::ST_PSTEP: begin
            if (expo_ff == '0) begin
               state_in = rasp_pkg::ST_ACCUM;
            end else if (phase_ff || expo_ff[0]) begin
               state_in = rasp_pkg::ST_MUL;
            end
         end
         rasp_pkg::ST_MUL: begin
            if (bit_ff == '0) state_in = rasp_pkg::ST_PSTEP;
         end
         rasp_pkg::ST_ACCUM: begin
            state_in = (idx_ff == hi_ff) ? rasp_pkg::ST_DONE : rasp_pkg::ST_ISSUE;
         end
         rasp_pkg::ST_KBIT: begin
            state_in = (bit_ff == '0) ? rasp_pkg::ST_DONE : rasp_pkg::ST_ISSUE;
         end
         rasp_pkg::ST_DONE: begin
            if (!rsp_valid_ff) state_in = rasp_pkg::ST_IDLE;
         end
         default: state_in = rasp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      opnd_in      = opnd_ff;
      expo_in      = expo_ff;
      mod_in       = mod_ff;
      val_in       = val_ff;
      ans_in       = ans_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      base_in      = base_ff;
      pacc_in      = pacc_ff;
      sum_in       = sum_ff;
      phase_in     = phase_ff;
      tgt_acc_in   = tgt_acc_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_we       = 1'b0;
      ram_addr     = idx_ff;
      ram_wdata    = wr_val;
      req_tready   = (state_ff == rasp_pkg::ST_IDLE);

      case (state_ff)
         rasp_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            idx_in    = idx_ff + AW'(1);
         end
         rasp_pkg::ST_IDLE: begin
            kind_in = rasp_pkg::req_kind_type'(req_tuser);
            lo_in   = new_lo;
            hi_in   = new_hi;
            idx_in  = new_lo;
            opnd_in = f_opnd;
            mod_in  = f_mod;
            bit_in  = CW'(VW - 1);
            ans_in  = '0;
            cnt_in  = '0;
            sum_in  = '0;
            res_in  = '0;
            err_in  = (req_tuser == rasp_pkg::REQ_KTH);
         end
         rasp_pkg::ST_USE: begin
            case (kind_ff)
               rasp_pkg::REQ_ADD, rasp_pkg::REQ_ASSIGN: begin
                  ram_we = 1'b1;
                  idx_in = idx_ff + AW'(1);
               end
               rasp_pkg::REQ_KTH: begin
                  if (ram_rdata <= cand) cnt_in = cnt_ff + (AW+1)'(1);
                  if (idx_ff != hi_ff) idx_in = idx_ff + AW'(1);
               end
               default: begin
                  val_in = ram_rdata;
                  r_in   = '0;
                  bit_in = CW'(VW - 1);
               end
            endcase
         end
         rasp_pkg::ST_REDUCE: begin
            r_in   = step_out;
            bit_in = bit_ff - CW'(1);
            if (bit_ff == '0) begin
               base_in  = step_out;
               pacc_in  = MW'(m_not_one);
               expo_in  = opnd_ff;
               phase_in = 1'b0;
            end
         end
         rasp_pkg::ST_PSTEP: begin
            r_in   = '0;
            bit_in = CW'(MW - 1);
            if (expo_ff != '0) begin
               if (!phase_ff) begin
                  if (expo_ff[0]) begin
                     x_in       = pacc_ff;
                     y_in       = base_ff;
                     tgt_acc_in = 1'b1;
                  end else begin
                     phase_in = 1'b1;
                  end
               end else begin
                  x_in       = base_ff;
                  y_in       = base_ff;
                  tgt_acc_in = 1'b0;
               end
            end
         end
         rasp_pkg::ST_MUL: begin
            r_in   = step_out;
            y_in   = {y_ff[MW-2:0], 1'b0};
            bit_in = bit_ff - CW'(1);
            if (bit_ff == '0) begin
               if (tgt_acc_ff) begin
                  pacc_in  = step_out;
                  phase_in = 1'b1;
               end else begin
                  base_in  = step_out;
                  phase_in = 1'b0;
                  expo_in  = expo_ff >> 1;
               end
            end
         end
         rasp_pkg::ST_ACCUM: begin
            sum_in = acc_sum[MW-1:0];
            res_in = VW'(acc_sum[MW-1:0]);
            idx_in = idx_ff + AW'(1);
         end
         rasp_pkg::ST_KBIT: begin
            ans_in = ans_next;
            res_in = ans_next;
            err_in = 1'b0;
            bit_in = bit_ff - CW'(1);
            cnt_in = '0;
            idx_in = lo_ff;
         end
         rasp_pkg::ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_wide[47:0];
               rsp_err_in   = err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rasp_pkg::ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      opnd_ff     <= opnd_in;
      expo_ff     <= expo_in;
      mod_ff      <= mod_in;
      val_ff      <= val_in;
      ans_ff      <= ans_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      r_ff        <= r_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      base_ff     <= base_in;
      pacc_ff     <= pacc_in;
      sum_ff      <= sum_in;
      phase_ff    <= phase_in;
      tgt_acc_ff  <= tgt_acc_in;
      res_ff      <= res_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
